>>> design/ordered_table_with_overflow_fifo_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the ordered table unit.
// ----------------------------------------------------------------------------
`ifndef ORDERED_TABLE_WITH_OVERFLOW_FIFO_UNIT_MACROS_SVH
`define ORDERED_TABLE_WITH_OVERFLOW_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define OTWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define OTWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/otwf_pkg.sv
// ----------------------------------------------------------------------------
// otwf_pkg
// Types and constants shared by the ordered table unit.
// ----------------------------------------------------------------------------
package otwf_pkg;

    localparam int KEY_W    = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    // Request operation codes
    localparam logic OP_ARRIVAL   = 1'b0;
    localparam logic OP_DEPARTURE = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic capture;  // latch compare result against the probe key
        logic shift;    // close the gap behind the first match
        logic write;    // load the common load key
    } cell_ctrl_t;

endpackage

>>> design/otwf_if.sv
// ----------------------------------------------------------------------------
// otwf request / response interfaces
// Valid/ready channels carrying the unit's request and response payloads.
// ----------------------------------------------------------------------------
interface otwf_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [otwf_pkg::KEY_W-1:0]  key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface otwf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [otwf_pkg::STATUS_W-1:0] status;
    logic                          promoted;
    logic [otwf_pkg::COUNT_W-1:0]  table_count;
    logic [otwf_pkg::COUNT_W-1:0]  queue_count;

    modport source (output valid, output status, output promoted,
                    output table_count, output queue_count, input ready);
    modport sink   (input valid, input status, input promoted,
                    input table_count, input queue_count, output ready);
endinterface

>>> design/ordered_table_with_overflow_fifo_unit.sv
// ----------------------------------------------------------------------------
// ordered_table_with_overflow_fifo_unit
// Ordered key table with a circular overflow FIFO.
// ----------------------------------------------------------------------------
// Each request runs in a transfer cycle and an execute state: in the
// transfer cycle every table cell compares its key with the request key;
// in the next cycle the first-match chain across the cells resolves, and
// once the response register is free, matching and later cells shift down,
// the counters update and the response is registered. A new request is
// taken right after, not before the last one is through; a response that
// is not taken holds the execute state until the response register frees.
// The overflow FIFO is a RAM with registered read whose head entry is read
// ahead during the compare cycle. No clearing pass follows reset.
module ordered_table_with_overflow_fifo_unit #(
    parameter int TABLE_SLOTS = 8,
    parameter int WAIT_SLOTS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    otwf_req_if.sink   req,
    otwf_rsp_if.source rsp
);

    `include "ordered_table_with_overflow_fifo_unit_macros.svh"

    localparam int FILL_W  = $clog2(TABLE_SLOTS + 1);
    localparam int WIDX_W  = $clog2(WAIT_SLOTS);
    localparam int WFILL_W = $clog2(WAIT_SLOTS + 1);
    localparam logic [FILL_W-1:0]  TABLE_FULL = FILL_W'(TABLE_SLOTS);
    localparam logic [WFILL_W-1:0] WAIT_FULL  = WFILL_W'(WAIT_SLOTS);
    localparam logic [WIDX_W-1:0]  WAIT_LAST  = WIDX_W'(WAIT_SLOTS - 1);

    otwf_pkg::state_t  state_reg;
    otwf_pkg::state_t  state_next;

    logic                       op_reg;
    logic [otwf_pkg::KEY_W-1:0] req_key_reg;

    logic [FILL_W-1:0]  fill_reg,  fill_next;
    logic [WIDX_W-1:0]  head_reg,  head_next;
    logic [WIDX_W-1:0]  tail_reg,  tail_next;
    logic [WFILL_W-1:0] wfill_reg, wfill_next;

    logic                            rsp_valid_reg, rsp_valid_next;
    otwf_pkg::status_t               status_reg,    status_next;
    logic                            promoted_reg,  promoted_next;
    logic [otwf_pkg::COUNT_W-1:0]    tcount_reg,    tcount_next;
    logic [otwf_pkg::COUNT_W-1:0]    qcount_reg,    qcount_next;

    logic                       req_xfer;
    logic                       commit;
    logic                       found;
    logic                       write_en;
    logic [FILL_W-1:0]          write_idx;
    logic                       shift_en;
    logic                       ram_we;
    logic [otwf_pkg::KEY_W-1:0] ram_rdata;
    logic [otwf_pkg::KEY_W-1:0] load_key;

    logic [otwf_pkg::KEY_W-1:0] cell_key [TABLE_SLOTS];
    logic [TABLE_SLOTS:0]       hit_chain;
    otwf_pkg::cell_ctrl_t       cell_ctrl [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]     occupied;

    // Handshake
    assign req.ready = (state_reg == otwf_pkg::S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign commit    = (state_reg == otwf_pkg::S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Overflow FIFO storage; head entry is read every cycle
    otwf_ram #(
        .WIDTH (otwf_pkg::KEY_W),
        .DEPTH (WAIT_SLOTS)
    ) u_wait_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (req_key_reg),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    // Table cell chain
    assign hit_chain[0] = 1'b0;
    assign load_key     = (op_reg == otwf_pkg::OP_ARRIVAL) ? req_key_reg : ram_rdata;
    assign found        = hit_chain[TABLE_SLOTS];

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        assign occupied[i]         = FILL_W'(i) < fill_reg;
        assign cell_ctrl[i].capture = req_xfer;
        assign cell_ctrl[i].shift   = shift_en;
        assign cell_ctrl[i].write   = write_en && (write_idx == FILL_W'(i));

        otwf_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .occupied    (occupied[i]),
            .probe_key   (req.key),
            .load_key    (load_key),
            .next_key    (cell_key[(i + 1 < TABLE_SLOTS) ? i + 1 : i]),
            .hit_before  (hit_chain[i]),
            .hit_through (hit_chain[i + 1]),
            .key         (cell_key[i])
        );
    end

    // Operation decode and counter update
    always_comb
    begin
        fill_next     = fill_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        wfill_next    = wfill_reg;
        status_next   = status_reg;
        promoted_next = 1'b0;
        write_en      = 1'b0;
        write_idx     = fill_reg;
        shift_en      = 1'b0;
        ram_we        = 1'b0;
        if (op_reg == otwf_pkg::OP_ARRIVAL)
        begin
            if (fill_reg != TABLE_FULL)
            begin
                write_en    = commit;
                fill_next   = fill_reg + 1'b1;
                status_next = otwf_pkg::ST_STORED;
            end
            else if (wfill_reg != WAIT_FULL)
            begin
                ram_we      = commit;
                tail_next   = (tail_reg == WAIT_LAST) ? '0 : tail_reg + 1'b1;
                wfill_next  = wfill_reg + 1'b1;
                status_next = otwf_pkg::ST_QUEUED;
            end
            else
            begin
                status_next = otwf_pkg::ST_REJECTED;
            end
        end
        else
        begin
            if (found)
            begin
                shift_en    = commit;
                status_next = otwf_pkg::ST_REMOVED;
                if (wfill_reg != '0)
                begin
                    // oldest waiting key refills the freed top slot
                    write_en      = commit;
                    write_idx     = fill_reg - 1'b1;
                    head_next     = (head_reg == WAIT_LAST) ? '0 : head_reg + 1'b1;
                    wfill_next    = wfill_reg - 1'b1;
                    promoted_next = 1'b1;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            else
            begin
                status_next = otwf_pkg::ST_NOT_FOUND;
            end
        end
        tcount_next = otwf_pkg::COUNT_W'(fill_next);
        qcount_next = otwf_pkg::COUNT_W'(wfill_next);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            otwf_pkg::S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = otwf_pkg::S_EXEC;
                end
            end
            otwf_pkg::S_EXEC:
            begin
                if (commit)
                begin
                    state_next = otwf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = otwf_pkg::S_IDLE;
            end
        endcase
    end

    // Response valid: set on commit, cleared on transfer
    assign rsp_valid_next = commit || (rsp_valid_reg && !rsp.ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= otwf_pkg::S_IDLE;
            fill_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            wfill_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                fill_reg  <= fill_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                wfill_reg <= wfill_next;
            end
        end
    end

    // Request and response payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg      <= req.operation;
            req_key_reg <= req.key;
        end
        if (commit)
        begin
            status_reg   <= status_next;
            promoted_reg <= promoted_next;
            tcount_reg   <= tcount_next;
            qcount_reg   <= qcount_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.promoted    = promoted_reg;
    assign rsp.table_count = tcount_reg;
    assign rsp.queue_count = qcount_reg;

    // Checks
    `OTWF_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= TABLE_FULL, "table fill out of range")
    `OTWF_ASSERT_NOW(a_queue_needs_full, clk, rst_n, wfill_reg != '0, fill_reg == TABLE_FULL, "queue holds keys while table has room")
    `OTWF_ASSERT_NOW(a_ptr_consistent, clk, rst_n, head_reg != tail_reg, (wfill_reg != '0) && (wfill_reg != WAIT_FULL), "FIFO pointers disagree with fill")
    `OTWF_ASSERT_NOW(a_promote_removed, clk, rst_n, rsp.valid && rsp.promoted, rsp.status == otwf_pkg::ST_REMOVED, "promotion without removal")
    `OTWF_ASSERT_NEXT(a_commit_valid, clk, rst_n, commit, rsp.valid, "committed response not presented")

endmodule

>>> design/otwf_ram.sv
// ----------------------------------------------------------------------------
// otwf_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otwf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/otwf_cell.sv
// ----------------------------------------------------------------------------
// otwf_cell
// One table slot: holds a key, compares it, and passes the first-match chain.
// ----------------------------------------------------------------------------
module otwf_cell (
    input  logic                       clk,
    input  otwf_pkg::cell_ctrl_t       ctrl,
    input  logic                       occupied,
    input  logic [otwf_pkg::KEY_W-1:0] probe_key,
    input  logic [otwf_pkg::KEY_W-1:0] load_key,
    input  logic [otwf_pkg::KEY_W-1:0] next_key,
    input  logic                       hit_before,
    output logic                       hit_through,
    output logic [otwf_pkg::KEY_W-1:0] key
);

    logic [otwf_pkg::KEY_W-1:0] key_reg;
    logic [otwf_pkg::KEY_W-1:0] key_next;
    logic                       match_reg;
    logic                       match_next;

    // Compare stage: latch the match at request transfer
    assign match_next = ctrl.capture ? (occupied && (key_reg == probe_key)) : match_reg;

    // First-match chain: set from the first matching slot upward
    assign hit_through = hit_before | match_reg;

    // Load beats shift; shifting cells take the key from the slot above
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.write)
        begin
            key_next = load_key;
        end
        else if (ctrl.shift && hit_through)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        match_reg <= match_next;
    end

    assign key = key_reg;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// ordered_table_with_overflow_fifo_unit testbench
// Drives arrivals and departures into the unit and checks every response
// against a queue-based model of the key table and its overflow FIFO.
// Directed tests come first, then random traffic under several
// handshake idle and stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_SLOTS = 8;
    localparam int WAIT_SLOTS  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 16;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        otwf_pkg::status_t                status;
        logic                             promoted;
        logic [otwf_pkg::COUNT_W-1:0]     table_count;
        logic [otwf_pkg::COUNT_W-1:0]     queue_count;
    } reply_t;

    logic clk;
    logic rst_n;

    otwf_req_if req_ch ();
    otwf_rsp_if rsp_ch ();

    ordered_table_with_overflow_fifo_unit #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .WAIT_SLOTS  (WAIT_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model state: keys parked in the table, keys waiting in the FIFO
    logic [otwf_pkg::KEY_W-1:0] lot_keys[$];
    logic [otwf_pkg::KEY_W-1:0] waiting_keys[$];
    reply_t                     expected_replies[$];
    logic [otwf_pkg::KEY_W-1:0] plate_pool[POOL_SIZE];

    int sender_idle_pct;
    int receiver_stall_pct;
    int error_count;
    int cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ordered_table_with_overflow_fifo_unit regression: fail");
            $finish;
        end
    end

    // Response side: random stalls per current mix
    always @(negedge clk)
    begin
        rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    // Apply one step to the model and return the response it gives
    function automatic reply_t predict_lot_step(input logic op,
                                                input logic [otwf_pkg::KEY_W-1:0] key);
        reply_t r;
        int     hit;
        r.promoted = 1'b0;
        hit = -1;
        if (op == otwf_pkg::OP_ARRIVAL)
        begin
            if (lot_keys.size() < TABLE_SLOTS)
            begin
                lot_keys.push_back(key);
                r.status = otwf_pkg::ST_STORED;
            end
            else if (waiting_keys.size() < WAIT_SLOTS)
            begin
                waiting_keys.push_back(key);
                r.status = otwf_pkg::ST_QUEUED;
            end
            else
            begin
                r.status = otwf_pkg::ST_REJECTED;
            end
        end
        else
        begin
            // first match only; the FIFO is never searched
            foreach (lot_keys[i])
            begin
                if (hit < 0 && lot_keys[i] == key)
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = otwf_pkg::ST_NOT_FOUND;
            end
            else
            begin
                lot_keys.delete(hit);
                r.status = otwf_pkg::ST_REMOVED;
                if (waiting_keys.size() > 0)
                begin
                    lot_keys.push_back(waiting_keys.pop_front());
                    r.promoted = 1'b1;
                end
            end
        end
        r.table_count = otwf_pkg::COUNT_W'(lot_keys.size());
        r.queue_count = otwf_pkg::COUNT_W'(waiting_keys.size());
        return r;
    endfunction

    // Request transfer: optional idle cycles, then hold until ready
    task automatic send_request(input logic op, input logic [otwf_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.key       = key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_replies.push_back(predict_lot_step(op, key));
    endtask

    // Hold the request side idle until every response is back
    task automatic wait_for_replies();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // Response checker
    always @(posedge clk)
    begin : check_reply
        reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("response transfer with nothing expected");
                error_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.promoted !== want.promoted)
                begin
                    $error("promoted: expected %0d, actual %0d",
                           want.promoted, rsp_ch.promoted);
                    error_count++;
                end
                if (rsp_ch.table_count !== want.table_count)
                begin
                    $error("table_count: expected %0d, actual %0d",
                           want.table_count, rsp_ch.table_count);
                    error_count++;
                end
                if (rsp_ch.queue_count !== want.queue_count)
                begin
                    $error("queue_count: expected %0d, actual %0d",
                           want.queue_count, rsp_ch.queue_count);
                    error_count++;
                end
            end
        end
    end

    // Departure from an empty table
    task automatic test_empty_departure();
        send_request(otwf_pkg::OP_DEPARTURE, '0);
        send_request(otwf_pkg::OP_DEPARTURE, '1);
    endtask

    // Fill the table, then the FIFO, then one more is turned away
    task automatic test_fill_and_overflow();
        send_request(otwf_pkg::OP_ARRIVAL, '0);
        send_request(otwf_pkg::OP_ARRIVAL, '1);
        send_request(otwf_pkg::OP_ARRIVAL, 64'h0000_4142_4331_3233);
        send_request(otwf_pkg::OP_ARRIVAL, 64'h0000_4142_4331_3233);
        send_request(otwf_pkg::OP_ARRIVAL, 64'h8000_0000_0000_0000);
        send_request(otwf_pkg::OP_ARRIVAL, 64'h0000_0000_0000_0001);
        send_request(otwf_pkg::OP_ARRIVAL, 64'hDEAD_BEEF_5A5A_A5A5);
        send_request(otwf_pkg::OP_ARRIVAL, 64'h0000_0000_5A5A_3939);
        for (int i = 0; i < WAIT_SLOTS; i++)
            send_request(otwf_pkg::OP_ARRIVAL, 64'h5100_0000_0000_0000 | i);
        send_request(otwf_pkg::OP_ARRIVAL, 64'h7777_7777_7777_7777);
    endtask

    // Queued key not found, duplicate and other removals with promotion, a miss
    task automatic test_departures();
        send_request(otwf_pkg::OP_DEPARTURE, 64'h5100_0000_0000_0003);
        send_request(otwf_pkg::OP_DEPARTURE, 64'h0000_4142_4331_3233);
        send_request(otwf_pkg::OP_DEPARTURE, '1);
        send_request(otwf_pkg::OP_DEPARTURE, 64'h0000_0000_0000_0001);
        send_request(otwf_pkg::OP_DEPARTURE, 64'h1234_5678_9ABC_DEF0);
    endtask

    // Random traffic: arrivals and departures of parked, queued, pooled and random keys,
    // with filling and draining trends so both stores wrap and overflow
    task automatic test_random_traffic(input idle_mode_t mode, input int count);
        logic                       op;
        logic [otwf_pkg::KEY_W-1:0] key;
        bit                         filling;
        int                         pick;
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
            default:       begin sender_idle_pct = 23; receiver_stall_pct = 23; end
        endcase
        filling = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            // pause until all responses are back, mid phase
            if (n == count / 2)
                wait_for_replies();
            if ($urandom_range(23) == 0)
                filling = !filling;
            if (lot_keys.size() == 0)
                filling = 1'b1;
            else if (waiting_keys.size() == WAIT_SLOTS && $urandom_range(3) == 0)
                filling = 1'b0;
            op = ($urandom_range(99) < (filling ? 70 : 30)) ?
                 otwf_pkg::OP_ARRIVAL : otwf_pkg::OP_DEPARTURE;
            pick = $urandom_range(99);
            if (op == otwf_pkg::OP_DEPARTURE && lot_keys.size() > 0 && pick < 75)
                key = lot_keys[$urandom_range(lot_keys.size() - 1)];
            else if (op == otwf_pkg::OP_DEPARTURE && waiting_keys.size() > 0 && pick < 85)
                key = waiting_keys[$urandom_range(waiting_keys.size() - 1)];
            else if (pick < 60)
                key = plate_pool[$urandom_range(POOL_SIZE - 1)];
            else
                key = {$urandom(), $urandom()};
            send_request(op, key);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = otwf_pkg::OP_ARRIVAL;
        req_ch.key         = '0;
        rsp_ch.ready       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        cycle_count        = 0;
        foreach (plate_pool[i])
            plate_pool[i] = {$urandom(), $urandom()};

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_empty_departure();
        test_fill_and_overflow();
        test_departures();
        test_random_traffic(IDLE_NONE, 190);
        test_random_traffic(IDLE_SENDER, 185);
        test_random_traffic(IDLE_RECEIVER, 185);
        test_random_traffic(IDLE_BOTH, 190);

        wait_for_replies();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("ordered_table_with_overflow_fifo_unit regression: pass");
        else
            $display("ordered_table_with_overflow_fifo_unit regression: fail");
        $finish;
    end

endmodule

>>> ordered_table_with_overflow_fifo_unit.f
+incdir+design
design/otwf_pkg.sv
design/otwf_if.sv
design/otwf_ram.sv
design/otwf_cell.sv
design/ordered_table_with_overflow_fifo_unit.sv
dv/testbench.sv
